>>> rtl/core/hkst_pkg.sv
// Package for the held key slot table.
// Holds the item types, the slot entry type, opcodes and the sequencer states.
// Depends on nothing.
package hkst_pkg;

    localparam int KEY_W   = 25;
    localparam int HOLD_W  = 31;
    localparam int AMT_W   = 16;
    localparam int INDEX_W = 6;

    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_LOOK    = 2'd3
    } op_t;

    typedef struct packed {
        op_t               opcode;
        logic [KEY_W-1:0]  key_code;
        logic [AMT_W-1:0]  tick_amount;
    } req_item_t;

    typedef struct packed {
        logic               key_found;
        logic               key_pressed;
        logic [HOLD_W-1:0]  hold_time;
        logic [INDEX_W-1:0] slot_index;
    } rsp_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              pressed;
        logic [HOLD_W-1:0] hold;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/core/hkst_slot_mem.sv
// Slot memory of the held key slot table: one write port, one registered read port.
// Per-entry valid bits make entries never written read as an all-zero slot.
// Depends on hkst_pkg.
module hkst_slot_mem #(
    parameter int SLOT_COUNT = 8,
    parameter int IDX_W      = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  hkst_pkg::slot_t     wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output hkst_pkg::slot_t     rd_data
);
    import hkst_pkg::*;

    slot_t                   mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   valid_reg;
    slot_t                   rd_data_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/core/hkst_ctrl.sv
// Sequencer of the held key slot table: scans every slot through the memory read
// port, applies ticks in place, then writes the press or release and forms the result.
// Depends on hkst_pkg.
module hkst_ctrl #(
    parameter int SLOT_COUNT = 8,
    parameter int IDX_W      = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  hkst_pkg::req_item_t    req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output hkst_pkg::rsp_item_t    rsp,
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_addr,
    output hkst_pkg::slot_t        wr_data,
    output logic                   rd_en,
    output logic [IDX_W-1:0]       rd_addr,
    input  hkst_pkg::slot_t        rd_data
);
    import hkst_pkg::*;

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic               proc_valid_reg;
    logic [IDX_W-1:0]   proc_idx_reg;
    req_item_t          req_reg;

    logic               match_found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic               match_pressed_reg;
    logic [HOLD_W-1:0]  match_hold_reg;
    logic               unp_found_reg;
    logic [IDX_W-1:0]   unp_idx_reg;
    logic [HOLD_W-1:0]  best_reg;
    logic [IDX_W-1:0]   long_idx_reg;

    logic               rsp_valid_reg;
    rsp_item_t          rsp_reg;
    rsp_item_t          rsp_next;

    logic [HOLD_W:0]    tick_sum;
    logic [HOLD_W-1:0]  tick_hold;
    logic               tick_write;
    logic [HOLD_W-1:0]  scan_hold;
    logic [IDX_W-1:0]   press_idx;
    logic               load_rsp;

    always_comb
    begin
        tick_sum  = {1'b0, rd_data.hold} + (HOLD_W + 1)'(req_reg.tick_amount);
        tick_hold = tick_sum[HOLD_W] ? HOLD_MAX : tick_sum[HOLD_W-1:0];
        tick_write = proc_valid_reg && (req_reg.opcode == OP_TICK) && rd_data.pressed;
        scan_hold  = tick_write ? tick_hold : rd_data.hold;
        if (match_found_reg)
        begin
            press_idx = match_idx_reg;
        end
        else if (unp_found_reg)
        begin
            press_idx = unp_idx_reg;
        end
        else
        begin
            press_idx = long_idx_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (proc_valid_reg && (proc_idx_reg == IDX_LAST))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = rd_cnt_reg[IDX_W-1:0];
        wr_en     = 1'b0;
        wr_addr   = proc_idx_reg;
        wr_data   = '{key: rd_data.key, pressed: rd_data.pressed, hold: tick_hold};
        load_rsp  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_SCAN:
            begin
                rd_en = (rd_cnt_reg < CNT_END);
                wr_en = tick_write;
            end
            ST_UPDATE:
            begin
                if (req_reg.opcode == OP_PRESS)
                begin
                    wr_en   = 1'b1;
                    wr_addr = press_idx;
                    wr_data = '{key: req_reg.key_code, pressed: 1'b1, hold: '0};
                end
                else if ((req_reg.opcode == OP_RELEASE) && match_found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = match_idx_reg;
                    wr_data = '{key: req_reg.key_code, pressed: 1'b0, hold: match_hold_reg};
                end
            end
            ST_FINISH:
            begin
                load_rsp = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_next = '0;
        if (req_reg.opcode == OP_PRESS)
        begin
            rsp_next.key_found   = 1'b1;
            rsp_next.key_pressed = 1'b1;
            rsp_next.slot_index  = INDEX_W'(press_idx);
        end
        else if (match_found_reg)
        begin
            rsp_next.key_found   = 1'b1;
            rsp_next.key_pressed = (req_reg.opcode == OP_RELEASE) ? 1'b0 : match_pressed_reg;
            rsp_next.hold_time   = match_hold_reg;
            rsp_next.slot_index  = INDEX_W'(match_idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_cnt_reg     <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            proc_valid_reg <= rd_en;
            proc_idx_reg   <= rd_addr;
            if (req_valid && req_ready)
            begin
                rd_cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg         <= req;
            match_found_reg <= 1'b0;
            unp_found_reg   <= 1'b0;
            best_reg        <= '0;
            long_idx_reg    <= '0;
        end
        else if (proc_valid_reg)
        begin
            if (!match_found_reg && (rd_data.key == req_reg.key_code))
            begin
                match_found_reg   <= 1'b1;
                match_idx_reg     <= proc_idx_reg;
                match_pressed_reg <= rd_data.pressed;
                match_hold_reg    <= scan_hold;
            end
            if (!unp_found_reg && !rd_data.pressed)
            begin
                unp_found_reg <= 1'b1;
                unp_idx_reg   <= proc_idx_reg;
            end
            if (rd_data.hold > best_reg)
            begin
                best_reg     <= rd_data.hold;
                long_idx_reg <= proc_idx_reg;
            end
        end
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/core/held_key_slot_table.sv
// Held key slot table: a table of key slots with pressed flags and hold times.
// Top level; instantiates hkst_ctrl and hkst_slot_mem, depends on hkst_pkg.
//
// Usage: an item on the req channel (valid/ready) names an operation and a key.
// Press claims a slot for the key, release clears its pressed flag, tick adds
// tick_amount to every pressed slot with saturation, and look changes nothing.
// Every item returns exactly one item on the rsp channel with the state of the
// named key after the operation.
// Each item scans all slots through the single read port of the slot memory,
// one slot per cycle, followed by a write step (ST_UPDATE) and a result step (ST_FINISH).
// req_ready is high only while no item is being worked on. The response sits
// in an output register, so the next item may be accepted while the previous
// result still waits; a stalled receiver holds the sequencer at its final
// cycle until the register frees up.
// Reset clears all slots to key 0, released, hold time zero, at once through
// per-slot valid bits; no clearing pass is needed.
module held_key_slot_table #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  hkst_pkg::req_item_t    req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output hkst_pkg::rsp_item_t    rsp
);
    import hkst_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_t              wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    slot_t              rd_data;

    hkst_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    hkst_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

endmodule

>>> rtl/core/hkst_checker.sv
// Port-level checks for the held key slot table, bound to the top level.
// Depends on hkst_pkg.
module hkst_checker #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  logic                   req_ready,
    input  hkst_pkg::req_item_t    req,
    input  logic                   rsp_valid,
    input  logic                   rsp_ready,
    input  hkst_pkg::rsp_item_t    rsp
);
    import hkst_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("Response item changed while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Request accepted while an item is in progress.");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.key_found |->
            !rsp.key_pressed && (rsp.hold_time == '0) && (rsp.slot_index == '0))
        else $error("Missing key reported with nonzero fields.");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp.slot_index) < SLOT_COUNT))
        else $error("Slot index beyond the table.");

    a_press_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.opcode == OP_PRESS) |=> !rsp_valid || rsp_ready ||
            $stable(rsp))
        else $error("Pending response disturbed by a new press item.");

endmodule

bind held_key_slot_table hkst_checker #(.SLOT_COUNT(SLOT_COUNT)) u_hkst_checker (.*);

>>> tb/held_key_slot_table_tb.sv
// Testbench for held_key_slot_table: a directed table, random key traffic and a back-to-back
// tick run, results checked against pinned values or a predictor of the slot table.
// Depends on hkst_pkg and the held_key_slot_table RTL.
module held_key_slot_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hkst_pkg::*;

    localparam int SLOTS          = 8;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int POOL_SIZE      = 12;
    localparam int TICK_RUN       = 64;
    localparam int MAX_REPORTS    = 50;

    typedef struct {
        req_item_t item;
        bit        pinned;
        rsp_item_t want;
    } dir_row_t;

    typedef struct {
        bit        pinned;
        rsp_item_t want;
    } pin_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    bit idle_on    = 1'b1;
    int stall_left = 0;
    int mismatches = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    logic [KEY_W-1:0]  tbl_key     [SLOTS];
    logic              tbl_pressed [SLOTS];
    logic [HOLD_W-1:0] tbl_hold    [SLOTS];

    rsp_item_t expected_q[$];
    pin_t      pin_q[$];
    dir_row_t  dir_rows[$];

    held_key_slot_table #(
        .SLOT_COUNT(SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int s = 0; s < SLOTS; s++)
        begin
            if (tbl_key[s] == key)
                return s;
        end
        return -1;
    endfunction

    function automatic rsp_item_t step_table(input req_item_t it);
        int                slot;
        logic [HOLD_W:0]   sum;
        logic [HOLD_W-1:0] best;
        rsp_item_t         r;
        case (it.opcode)
            OP_PRESS:
            begin
                slot = find_slot(it.key_code);
                if (slot < 0)
                begin
                    for (int s = SLOTS - 1; s >= 0; s--)
                    begin
                        if (!tbl_pressed[s])
                            slot = s;
                    end
                end
                if (slot < 0)
                begin
                    slot = 0;
                    best = '0;
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (tbl_hold[s] > best)
                        begin
                            best = tbl_hold[s];
                            slot = s;
                        end
                    end
                end
                tbl_key[slot]     = it.key_code;
                tbl_pressed[slot] = 1'b1;
                tbl_hold[slot]    = '0;
            end
            OP_RELEASE:
            begin
                slot = find_slot(it.key_code);
                if (slot >= 0)
                    tbl_pressed[slot] = 1'b0;
            end
            OP_TICK:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (tbl_pressed[s])
                    begin
                        sum = {1'b0, tbl_hold[s]} + it.tick_amount;
                        tbl_hold[s] = (sum > HOLD_MAX) ? HOLD_MAX : sum[HOLD_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
        slot = find_slot(it.key_code);
        r = '0;
        if (slot >= 0)
        begin
            r.key_found   = 1'b1;
            r.key_pressed = tbl_pressed[slot];
            r.hold_time   = tbl_hold[slot];
            r.slot_index  = slot[INDEX_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int item_no,
                                   input longint got, input longint want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch: %s on result %0d, got %0h, expected %0h",
                     what, item_no, got, want);
        mismatches++;
    endtask

    function automatic void add_row(input op_t op, input logic [KEY_W-1:0] key,
                                    input logic [AMT_W-1:0] amount, input bit pinned,
                                    input logic found, input logic pressed,
                                    input logic [HOLD_W-1:0] hold,
                                    input logic [INDEX_W-1:0] index);
        dir_row_t row;
        row.item.opcode      = op;
        row.item.key_code    = key;
        row.item.tick_amount = amount;
        row.pinned           = pinned;
        row.want.key_found   = found;
        row.want.key_pressed = pressed;
        row.want.hold_time   = hold;
        row.want.slot_index  = index;
        dir_rows.push_back(row);
    endfunction

    // The caller stands at a rising edge; returns at the edge that accepts the item.
    task automatic send_item(input req_item_t it, input bit pinned, input rsp_item_t want);
        pin_t pin;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        pin.pinned = pinned;
        pin.want   = want;
        pin_q.push_back(pin);
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!idle_on)
            rsp_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            rsp_ready  <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor
        rsp_item_t want;
        rsp_item_t predicted;
        pin_t      pin;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                    report_mismatch("result with nothing expected", results_seen, rsp, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.key_found !== want.key_found)
                        report_mismatch("key_found", results_seen, rsp.key_found,
                                        want.key_found);
                    if (rsp.key_pressed !== want.key_pressed)
                        report_mismatch("key_pressed", results_seen, rsp.key_pressed,
                                        want.key_pressed);
                    if (rsp.hold_time !== want.hold_time)
                        report_mismatch("hold_time", results_seen, rsp.hold_time,
                                        want.hold_time);
                    if (rsp.slot_index !== want.slot_index)
                        report_mismatch("slot_index", results_seen, rsp.slot_index,
                                        want.slot_index);
                end
            end
            if (req_valid && req_ready)
            begin
                pin       = pin_q.pop_front();
                predicted = step_table(req);
                expected_q.push_back(pin.pinned ? pin.want : predicted);
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        req_item_t         it;
        logic [KEY_W-1:0]  key_pool [POOL_SIZE];
        logic [KEY_W-1:0]  sat_keys [SLOTS];
        logic [31:0]       rnd;
        int                roll;

        foreach (tbl_key[s])
        begin
            tbl_key[s]     = '0;
            tbl_pressed[s] = 1'b0;
            tbl_hold[s]    = '0;
        end

        add_row(OP_LOOK,    25'h0000000, 16'h0000, 1'b1, 1'b1, 1'b0, 31'h0,    6'd0);
        add_row(OP_LOOK,    25'h1FFFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_RELEASE, 25'h1555555, 16'h0000, 1'b1, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_TICK,    25'h0000000, 16'hFFFF, 1'b1, 1'b1, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h1FFFFFF, 16'h0000, 1'b1, 1'b1, 1'b1, 31'h0,    6'd0);
        add_row(OP_TICK,    25'h1FFFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 31'hFFFF, 6'd0);
        add_row(OP_PRESS,   25'h0000000, 16'h1234, 1'b1, 1'b1, 1'b1, 31'h0,    6'd1);
        add_row(OP_TICK,    25'h0000000, 16'h0001, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_RELEASE, 25'h0000000, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h0AAAAAA, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h1555555, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h0000001, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h1000000, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h0F0F0F0, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h10F0F0F, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h0123456, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_TICK,    25'h0AAAAAA, 16'h8000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h1ABCDEF, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_LOOK,    25'h1FFFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h1555555, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_RELEASE, 25'h1555555, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_LOOK,    25'h1555555, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_PRESS,   25'h0FEDCBA, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_TICK,    25'h0FEDCBA, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);
        add_row(OP_LOOK,    25'h0000001, 16'h0000, 1'b0, 1'b0, 1'b0, 31'h0,    6'd0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].item, dir_rows[r].pinned, dir_rows[r].want);
        req_valid <= 1'b0;
        wait_drained();

        // Random traffic mostly names keys from a small pool so the table fills and evicts.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 200 == 0)
            begin
                foreach (key_pool[k])
                begin
                    rnd = $urandom;
                    key_pool[k] = (k == 0) ? '0 : rnd[KEY_W-1:0];
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 35)
                it.opcode = OP_PRESS;
            else if (roll < 60)
                it.opcode = OP_RELEASE;
            else if (roll < 85)
                it.opcode = OP_TICK;
            else
                it.opcode = OP_LOOK;
            rnd = $urandom;
            if ($urandom_range(0, 9) == 0)
                it.key_code = rnd[KEY_W-1:0];
            else
                it.key_code = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            rnd = $urandom;
            if ($urandom_range(0, 7) == 0)
                it.tick_amount = rnd[AMT_W-1:0];
            else
                it.tick_amount = AMT_W'($urandom_range(0, 300));
            send_item(it, 1'b0, '0);
        end
        req_valid <= 1'b0;
        wait_drained();

        // Final part runs without idling: fill the table and tick every slot back to back.
        idle_on = 1'b0;
        foreach (sat_keys[k])
        begin
            rnd = $urandom;
            sat_keys[k]    = rnd[KEY_W-1:0];
            it.opcode      = OP_PRESS;
            it.key_code    = sat_keys[k];
            it.tick_amount = '0;
            send_item(it, 1'b0, '0);
        end
        for (int n = 0; n < TICK_RUN; n++)
        begin
            it.opcode      = OP_TICK;
            it.key_code    = sat_keys[n % SLOTS];
            it.tick_amount = (n < TICK_RUN - 8) ? 16'hFFFF : AMT_W'($urandom);
            send_item(it, 1'b0, '0);
        end
        rnd = $urandom;
        it.opcode      = OP_PRESS;
        it.key_code    = rnd[KEY_W-1:0];
        it.tick_amount = '0;
        send_item(it, 1'b0, '0);
        foreach (sat_keys[k])
        begin
            it.opcode   = (k == 3) ? OP_RELEASE : OP_LOOK;
            it.key_code = sat_keys[k];
            send_item(it, 1'b0, '0);
        end
        it.opcode      = OP_TICK;
        it.key_code    = sat_keys[3];
        it.tick_amount = 16'hFFFF;
        send_item(it, 1'b0, '0);
        req_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("results never delivered", results_seen, 0, expected_q.size());
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/core/hkst_pkg.sv
rtl/core/hkst_slot_mem.sv
rtl/core/hkst_ctrl.sv
rtl/core/held_key_slot_table.sv
rtl/core/hkst_checker.sv
tb/held_key_slot_table_tb.sv
